// ----- rtl/core/gnad_pkg.sv -----
// Shared types and constants for the grouped nearest-anchor distance block.
package gnad_pkg;

	localparam logic [1:0] ACT_CLEAR = 2'd0;
	localparam logic [1:0] ACT_LOAD  = 2'd1;
	localparam logic [1:0] ACT_QUERY = 2'd2;

	typedef struct packed {
		logic [1:0]         action;
		logic [15:0]        group;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic [31:0] up_distance;
		logic        up_found;
		logic [31:0] down_distance;
		logic        down_found;
	} rsp_t;

	typedef struct packed {
		logic [15:0]        group;
		logic signed [31:0] value;
	} anchor_t;

	typedef struct packed {
		logic clear;
		logic load;
		logic query_start;
		logic scan_step;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic count_zero;
		logic scan_last;
		logic out_free;
	} status_t;

endpackage

// ----- rtl/core/grouped_nearest_anchor_distance.sv -----
// Grouped nearest-anchor distance: top level joining controller and datapath.
// Clear and load requests need no scan; a load into a full table is dropped.
// A query scans the stored anchors, one memory read per anchor, then one compare drain,
// and emits into the output register once it is free (an empty table skips scan and drain).
// One request in flight at a time; a finished result waits in the output register.
// arst_n clears the anchor count, controller state and output valid; memory is not cleared.
module grouped_nearest_anchor_distance import gnad_pkg::*; #(
	parameter int MAX_ANCHORS = 256
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	cmd_t    cmd;
	status_t st;

	gnad_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_action (req.action),
		.req_ready  (req_ready),
		.st         (st),
		.cmd        (cmd)
	);

	gnad_dpath #(
		.MAX_ANCHORS(MAX_ANCHORS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.st        (st),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> rsp_valid)
		else $error("result not presented after emit");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> st.out_free)
		else $error("emit would overwrite a pending result");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready && req.action == ACT_QUERY) |=> !req_ready)
		else $error("new request taken while query in progress");

endmodule

// ----- rtl/core/gnad_ctrl.sv -----
// Controller state machine: request intake, anchor scan sequencing, result hand-off.
module gnad_ctrl import gnad_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  logic [1:0] req_action,
	output logic       req_ready,
	input  status_t    st,
	output cmd_t       cmd
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SCAN  = 2'd1;
	localparam logic [1:0] S_DRAIN = 2'd2;
	localparam logic [1:0] S_DONE  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       accept;

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;

	always_comb begin
		state_d         = state_q;
		cmd             = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (req_action)
						ACT_CLEAR: cmd.clear = 1'b1;
						ACT_LOAD:  cmd.load  = 1'b1;
						ACT_QUERY: begin
							cmd.query_start = 1'b1;
							state_d = st.count_zero ? S_DONE : S_SCAN;
						end
						default: ;
					endcase
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (st.scan_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: state_d = S_DONE;
			S_DONE: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- rtl/core/gnad_dpath.sv -----
// Datapath: anchor memory, fill count, scan compare, distance and output register.
module gnad_dpath import gnad_pkg::*; #(
	parameter int MAX_ANCHORS = 256
) (
	input  logic    clk,
	input  logic    arst_n,
	input  req_t    req,
	input  cmd_t    cmd,
	output status_t st,
	output logic    rsp_valid,
	input  logic    rsp_ready,
	output rsp_t    rsp
);

	localparam int AW = (MAX_ANCHORS > 1) ? $clog2(MAX_ANCHORS) : 1;
	localparam int CW = $clog2(MAX_ANCHORS + 1);

	anchor_t            mem [MAX_ANCHORS];
	logic [CW-1:0]      count_q;
	logic [AW-1:0]      idx_q;
	anchor_t            key_q;
	anchor_t            rd_s1;
	logic               rdv_s1;
	logic               up_ok_q;
	logic               down_ok_q;
	logic signed [31:0] up_best_q;
	logic signed [31:0] down_best_q;
	logic               out_valid_q;
	rsp_t               rsp_q;
	logic               grp_hit;
	logic               up_hit;
	logic               down_hit;
	logic               not_full;

	assign not_full      = (count_q < CW'(MAX_ANCHORS));
	assign st.count_zero = (count_q == '0);
	assign st.scan_last  = ((CW'(idx_q) + CW'(1)) == count_q);
	assign st.out_free   = !out_valid_q || rsp_ready;

	assign grp_hit  = rdv_s1 && (rd_s1.group == key_q.group);
	assign up_hit   = grp_hit && ($signed(rd_s1.value) >= $signed(key_q.value)) &&
		(!up_ok_q || ($signed(rd_s1.value) < up_best_q));
	assign down_hit = grp_hit && ($signed(rd_s1.value) <= $signed(key_q.value)) &&
		(!down_ok_q || ($signed(rd_s1.value) > down_best_q));

	always_ff @(posedge clk) begin
		if (cmd.load && not_full) begin
			mem[count_q[AW-1:0]] <= '{group: req.group, value: req.value};
		end
		if (cmd.scan_step) begin
			rd_s1 <= mem[idx_q];
		end
		if (cmd.query_start) begin
			key_q <= '{group: req.group, value: req.value};
		end
		if (up_hit) begin
			up_best_q <= rd_s1.value;
		end
		if (down_hit) begin
			down_best_q <= rd_s1.value;
		end
		if (cmd.emit) begin
			rsp_q.up_found      <= up_ok_q;
			rsp_q.down_found    <= down_ok_q;
			rsp_q.up_distance   <= up_ok_q ? (up_best_q - key_q.value) : 32'd0;
			rsp_q.down_distance <= down_ok_q ? (key_q.value - down_best_q) : 32'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			idx_q       <= '0;
			rdv_s1      <= 1'b0;
			up_ok_q     <= 1'b0;
			down_ok_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				count_q <= '0;
			end else if (cmd.load && not_full) begin
				count_q <= count_q + CW'(1);
			end
			if (cmd.query_start) begin
				idx_q     <= '0;
				up_ok_q   <= 1'b0;
				down_ok_q <= 1'b0;
			end else begin
				if (cmd.scan_step) begin
					idx_q <= idx_q + AW'(1);
				end
				if (up_hit) begin
					up_ok_q <= 1'b1;
				end
				if (down_hit) begin
					down_ok_q <= 1'b1;
				end
			end
			rdv_s1 <= cmd.scan_step;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = rsp_q;

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for the grouped nearest-anchor distance block.
`timescale 1ns / 100ps

module tb_top;
	import gnad_pkg::*;

	localparam int MAX_ANCHORS = 256;
	localparam int ITEM_TARGET = 1950;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int GAP_CAP = 20;
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	typedef struct {
		bit   fixed;
		rsp_t d;
	} typed_distance_t;

	typedef struct {
		req_t            r;
		typed_distance_t t;
	} directed_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	logic signed [31:0] anchor_pos [MAX_ANCHORS];
	logic [15:0]        anchor_tag [MAX_ANCHORS];
	int                 anchor_total = 0;

	rsp_t            pending_distances [$];
	typed_distance_t row_distances [$];
	directed_row_t   directed_rows [$];

	int    errors = 0;
	int    sent_count = 0;
	int    checked_count = 0;
	int    cycle_count = 0;
	int    receiver_stall = 0;
	rsp_t  predicted;
	rsp_t  want;
	typed_distance_t row_pick;

	grouped_nearest_anchor_distance #(
		.MAX_ANCHORS(MAX_ANCHORS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always #4 clk = ~clk;

	// Table update and distance search for one accepted request.
	function automatic bit anchor_table_step(input req_t r, output rsp_t d);
		longint v;
		longint a;
		longint up_best;
		longint down_best;
		bit     up_ok;
		bit     down_ok;
		d = '0;
		anchor_table_step = 1'b0;
		up_ok = 1'b0;
		down_ok = 1'b0;
		up_best = 0;
		down_best = 0;
		v = longint'($signed(r.value));
		case (r.action)
			ACT_CLEAR: begin
				anchor_total = 0;
			end
			ACT_LOAD: begin
				if (anchor_total < MAX_ANCHORS) begin
					anchor_pos[anchor_total] = r.value;
					anchor_tag[anchor_total] = r.group;
					anchor_total++;
				end
			end
			ACT_QUERY: begin
				for (int k = 0; k < anchor_total; k++) begin
					if (anchor_tag[k] == r.group) begin
						a = longint'($signed(anchor_pos[k]));
						if (a >= v && (!up_ok || a < up_best)) begin
							up_best = a;
							up_ok = 1'b1;
						end
						if (a <= v && (!down_ok || a > down_best)) begin
							down_best = a;
							down_ok = 1'b1;
						end
					end
				end
				if (up_ok) begin
					d.up_distance = 32'(up_best - v);
				end
				if (down_ok) begin
					d.down_distance = 32'(v - down_best);
				end
				d.up_found = up_ok;
				d.down_found = down_ok;
				anchor_table_step = 1'b1;
			end
			default: ;
		endcase
	endfunction

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycle_count);
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Request acceptance: predict a query's distances, or take a row's fixed ones, and queue them.
	always @(posedge clk) begin
		if (arst_n && req_valid && req_ready) begin
			row_pick = row_distances.pop_front();
			if (anchor_table_step(req, predicted)) begin
				pending_distances.insert(pending_distances.size(),
					row_pick.fixed ? row_pick.d : predicted);
			end
		end
	end

	task automatic compare_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			rsp_ready <= ($urandom_range(0, 99) >= receiver_stall);
			if (rsp_valid && rsp_ready) begin
				if (pending_distances.size() == 0) begin
					$display("%0t: unexpected result: expected none, actual %h", $time, rsp);
					errors++;
				end else begin
					want = pending_distances.pop_front();
					compare_field("up_distance", want.up_distance, rsp.up_distance);
					compare_field("up_found", 32'(want.up_found), 32'(rsp.up_found));
					compare_field("down_distance", want.down_distance, rsp.down_distance);
					compare_field("down_found", 32'(want.down_found), 32'(rsp.down_found));
					checked_count++;
				end
			end
		end
	end

	task automatic send_request(input req_t r, input int idle_pct, input typed_distance_t t);
		int gap;
		gap = 0;
		while (gap < GAP_CAP && $urandom_range(0, 99) < idle_pct) begin
			gap++;
		end
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		row_distances.insert(row_distances.size(), t);
		req <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		if (r.action != ACT_UNUSED) begin
			sent_count++;
		end
	endtask

	task automatic wait_for_results();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending_distances.size() != 0) @(posedge clk);
	endtask

	task automatic add_row(input logic [1:0] act, input logic [15:0] tag,
			input logic [31:0] pos, input bit fixed, input logic [31:0] up_d,
			input bit up_f, input logic [31:0] dn_d, input bit dn_f);
		directed_row_t row;
		row.r.action = act;
		row.r.group = tag;
		row.r.value = pos;
		row.t.fixed = fixed;
		row.t.d.up_distance = up_d;
		row.t.d.up_found = up_f;
		row.t.d.down_distance = dn_d;
		row.t.d.down_found = dn_f;
		directed_rows.insert(directed_rows.size(), row);
	endtask

	function automatic logic [15:0] pick_tag();
		case ($urandom_range(0, 3))
			0: pick_tag = 16'h0000;
			1: pick_tag = 16'hFFFF;
			default: pick_tag = 16'($urandom);
		endcase
	endfunction

	function automatic logic signed [31:0] pick_value(input logic signed [31:0] base);
		case ($urandom_range(0, 5))
			0: begin
				case ($urandom_range(0, 3))
					0: pick_value = 32'h80000000;
					1: pick_value = 32'h7FFFFFFF;
					2: pick_value = 32'h00000000;
					default: pick_value = 32'hFFFFFFFF;
				endcase
			end
			1: pick_value = int'($urandom_range(0, 128)) - 64;
			2, 3: pick_value = base + int'($urandom_range(0, 200)) - 100;
			default: pick_value = $urandom;
		endcase
	endfunction

	// Clear, fill, then query the filled groups; a little noise mixed in.
	task automatic random_sequence(input int idle_pct);
		int                 pct;
		int                 n_load;
		int                 n_query;
		logic [15:0]        tags [3];
		logic signed [31:0] loaded [$];
		logic signed [31:0] base;
		req_t               r;
		typed_distance_t    none;
		none = '{fixed: 1'b0, d: '0};
		pct = ($urandom_range(0, 5) == 0) ? 0 : idle_pct;
		for (int k = 0; k < 3; k++) begin
			tags[k] = pick_tag();
		end
		base = $urandom;
		n_load = ($urandom_range(0, 11) == 0) ? $urandom_range(200, MAX_ANCHORS + 6)
			: $urandom_range(0, 12);
		n_query = $urandom_range(1, 8);
		r.action = ACT_CLEAR;
		r.group = 16'($urandom);
		r.value = $urandom;
		send_request(r, pct, none);
		for (int k = 0; k < n_load; k++) begin
			r.action = ($urandom_range(0, 29) == 0) ? ACT_UNUSED : ACT_LOAD;
			r.group = ($urandom_range(0, 19) == 0) ? 16'($urandom) : tags[$urandom_range(0, 2)];
			r.value = pick_value(base);
			send_request(r, pct, none);
			if (r.action == ACT_LOAD) begin
				loaded.insert(loaded.size(), r.value);
			end
		end
		for (int k = 0; k < n_query; k++) begin
			case ($urandom_range(0, 39))
				0: r.action = ACT_CLEAR;
				1: r.action = ACT_UNUSED;
				default: r.action = ACT_QUERY;
			endcase
			r.group = ($urandom_range(0, 6) == 0) ? pick_tag() : tags[$urandom_range(0, 2)];
			if (loaded.size() != 0 && $urandom_range(0, 1) == 0) begin
				r.value = loaded[$urandom_range(0, loaded.size() - 1)]
					+ int'($urandom_range(0, 6)) - 3;
			end else begin
				r.value = pick_value(base);
			end
			send_request(r, pct, none);
		end
	endtask

	initial begin
		int sender_idle;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		add_row(ACT_QUERY, 16'h0000, 32'h00000000, 1'b1, 32'h0, 1'b0, 32'h0, 1'b0);
		add_row(ACT_LOAD, 16'h0000, 32'h80000000, 1'b0, 32'h0, 1'b0, 32'h0, 1'b0);
		add_row(ACT_LOAD, 16'h0000, 32'h7FFFFFFF, 1'b0, 32'h0, 1'b0, 32'h0, 1'b0);
		add_row(ACT_QUERY, 16'h0000, 32'h80000000, 1'b1, 32'h0, 1'b1, 32'h0, 1'b1);
		add_row(ACT_QUERY, 16'h0000, 32'h7FFFFFFF, 1'b1, 32'h0, 1'b1, 32'h0, 1'b1);
		add_row(ACT_QUERY, 16'h0000, 32'h00000000, 1'b1, 32'h7FFFFFFF, 1'b1,
			32'h80000000, 1'b1);
		add_row(ACT_LOAD, 16'hFFFF, 32'h00000000, 1'b0, 32'h0, 1'b0, 32'h0, 1'b0);
		add_row(ACT_QUERY, 16'hFFFF, 32'h80000000, 1'b1, 32'h80000000, 1'b1, 32'h0, 1'b0);
		add_row(ACT_QUERY, 16'hFFFF, 32'h7FFFFFFF, 1'b1, 32'h0, 1'b0, 32'h7FFFFFFF, 1'b1);
		add_row(ACT_QUERY, 16'h1234, 32'h00000005, 1'b1, 32'h0, 1'b0, 32'h0, 1'b0);
		add_row(ACT_UNUSED, 16'hFFFF, 32'hFFFFFFFF, 1'b0, 32'h0, 1'b0, 32'h0, 1'b0);
		add_row(ACT_QUERY, 16'hFFFF, 32'hFFFFFFFF, 1'b1, 32'h1, 1'b1, 32'h0, 1'b0);
		add_row(ACT_LOAD, 16'h0005, 32'h7FFFFFFF, 1'b0, 32'h0, 1'b0, 32'h0, 1'b0);
		add_row(ACT_QUERY, 16'h0005, 32'h80000000, 1'b1, 32'hFFFFFFFF, 1'b1, 32'h0, 1'b0);
		add_row(ACT_LOAD, 16'h0006, 32'h80000000, 1'b0, 32'h0, 1'b0, 32'h0, 1'b0);
		add_row(ACT_QUERY, 16'h0006, 32'h7FFFFFFF, 1'b1, 32'h0, 1'b0, 32'hFFFFFFFF, 1'b1);
		add_row(ACT_LOAD, 16'h0007, 32'd100, 1'b0, 32'h0, 1'b0, 32'h0, 1'b0);
		add_row(ACT_LOAD, 16'h0007, -32'sd50, 1'b0, 32'h0, 1'b0, 32'h0, 1'b0);
		add_row(ACT_LOAD, 16'h0007, 32'd40, 1'b0, 32'h0, 1'b0, 32'h0, 1'b0);
		add_row(ACT_QUERY, 16'h0007, 32'd10, 1'b0, 32'h0, 1'b0, 32'h0, 1'b0);
		add_row(ACT_QUERY, 16'h0007, 32'd40, 1'b0, 32'h0, 1'b0, 32'h0, 1'b0);
		add_row(ACT_CLEAR, 16'hA5A5, 32'h5A5A5A5A, 1'b0, 32'h0, 1'b0, 32'h0, 1'b0);
		add_row(ACT_QUERY, 16'h0000, 32'h00000000, 1'b1, 32'h0, 1'b0, 32'h0, 1'b0);

		foreach (directed_rows[i]) begin
			send_request(directed_rows[i].r, 0, directed_rows[i].t);
		end
		wait_for_results();

		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin
					sender_idle = 0;
					receiver_stall = 0;
				end
				1: begin
					sender_idle = 67;
					receiver_stall = 0;
				end
				2: begin
					sender_idle = 0;
					receiver_stall = 67;
				end
				default: begin
					sender_idle = 22;
					receiver_stall = 22;
				end
			endcase
			while (sent_count < (p + 1) * ITEM_TARGET / 4) begin
				random_sequence(sender_idle);
			end
			wait_for_results();
		end

		repeat (MAX_ANCHORS + 8) @(posedge clk);
		if (pending_distances.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, pending_distances.size());
			errors++;
		end
		$display("Sent %0d requests and checked %0d query results under four idle patterns,",
			sent_count, checked_count);
		$display("with empty groups, exact hits, extreme distances, table overflow, unused actions.");
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
